// ----- design/rpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// rpfa_pkg
// Shared types and constants of the page frame allocator.
// ----------------------------------------------------------------------------
package rpfa_pkg;

  // pages held in one word of the used bitmap memory
  localparam int unsigned MW     = 32;
  localparam int unsigned MW_LOG = 5;
  // width of page numbers at the port, and of wide compares and run lengths
  localparam int unsigned PN_W   = 20;
  localparam int unsigned LW     = PN_W + 1;

  localparam logic [2:0] FN_ALLOC_ONE = 3'd0;
  localparam logic [2:0] FN_ALLOC_RUN = 3'd1;
  localparam logic [2:0] FN_REF       = 3'd2;
  localparam logic [2:0] FN_DEREF     = 3'd3;
  localparam logic [2:0] FN_QUERY     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  // address classes searched by alloc one, highest first
  localparam logic [2:0] CLS_LOWEST  = 3'd1;
  localparam logic [2:0] CLS_HIGHEST = 3'd4;

  localparam logic [5:0] MIN_ADDR_BITS = 6'd12;

  typedef struct packed {
    logic [2:0]  func;
    logic [19:0] page_number;
    logic [16:0] run_length;
    logic [5:0]  max_address_bits;
  } rpfa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_page;
    logic [15:0] ref_count;
    logic [16:0] used_pages;
  } rpfa_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_ONE_CLS,
    S_ONE_RD,
    S_ONE_CHK,
    S_RUN_RD,
    S_RUN_CHK,
    S_RUN_BIT,
    S_RUN_URD,
    S_RUN_UWR,
    S_RUN_CNT,
    S_PG_EX
  } rpfa_state_e;

  // first page of an address class
  function automatic logic [LW-1:0] class_first(input logic [2:0] cls);
    logic [LW-1:0] r;
    case (cls)
      3'd1:    r = LW'(0);
      3'd2:    r = LW'(16);
      3'd3:    r = LW'(256);
      3'd4:    r = LW'(4096);
      default: r = LW'(0);
    endcase
    return r;
  endfunction

  // last page of an address class
  function automatic logic [LW-1:0] class_last(input logic [2:0] cls);
    logic [LW-1:0] r;
    case (cls)
      3'd1:    r = LW'(15);
      3'd2:    r = LW'(255);
      3'd3:    r = LW'(4095);
      3'd4:    r = LW'(20'hFFFFF);
      default: r = LW'(0);
    endcase
    return r;
  endfunction

  // ones from bit lo up to bit hi
  function automatic logic [MW-1:0] range_mask(input logic [MW_LOG-1:0] lo,
                                               input logic [MW_LOG-1:0] hi);
    logic [MW-1:0] ones;
    ones = '1;
    return (ones << lo) & (ones >> (MW_LOG'(MW - 1) - hi));
  endfunction

  function automatic logic [MW_LOG-1:0] lowest_set(input logic [MW-1:0] v);
    logic [MW_LOG-1:0] r;
    r = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (v[i]) r = MW_LOG'(i);
    end
    return r;
  endfunction

endpackage

// ----- design/rpfa_ram.sv -----
// ----------------------------------------------------------------------------
// rpfa_ram
// Simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rpfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/refcounted_page_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_top
// Page frame allocator with a used bitmap and per-page reference counts.
// ----------------------------------------------------------------------------
//  port group        | direction | handshake
//  start, req_i      | in        | taken when start and not busy
//  busy              | out       | high while an item is in work or clearing
//  done_o, rsp_o     | out       | result valid for one cycle, no back pressure
//  cfg_we_i, cfg_wdata_i | in    | page_count written when cfg_we_i is high
//
//  reference, dereference, query: dispatch, execute, registered result.
//  alloc one: read and check states per 32-page word scanned, per class tried.
//  alloc run: read and check states per word scanned downward, a bit state
//  per page of words with mixed bits, then read and write states per word
//  and a count state per page of the run to mark it. A clearing pass after
//  reset clears the bitmap a word a cycle, busy high; results cannot stall.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_top
  import rpfa_pkg::*;
#(
  parameter int unsigned NUM_PAGES  = 65536,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  rpfa_req_t   req_i,
  output logic        done_o,
  output rpfa_rsp_t   rsp_o,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i
);

  localparam int unsigned PW  = $clog2(NUM_PAGES);
  localparam int unsigned CW  = PW + 1;
  localparam int unsigned WAW = PW - MW_LOG;
  localparam int unsigned NW  = (NUM_PAGES + MW - 1) / MW;

  rpfa_state_e state_q, state_d;
  rpfa_req_t   req_q;
  logic [CW-1:0]         cnt_q;
  logic [PW-1:0]         hint_q, hint_d;
  logic [CW-1:0]         used_q, used_d;
  logic [2:0]            cls_q, cls_d;
  logic [WAW-1:0]        w_q, w_d;
  logic [WAW-1:0]        clr_q, clr_d;
  logic [PW-1:0]         a_q, a_d, b_q, b_d, top_q, top_d;
  logic [PW-1:0]         p_q, p_d, e_q, e_d, q_q, q_d;
  logic [LW-1:0]         len_q, len_d;
  logic [MW_LOG-1:0]     bit_q, bit_d;
  logic [MW-1:0]         fw_q, fw_d;
  logic [1:0]            status_q, status_d;
  logic [PW-1:0]         rpage_q, rpage_d;
  logic [COUNT_BITS-1:0] rcnt_q, rcnt_d;
  logic                  done_q, done_d;

  // memories
  logic                  u_we;
  logic [WAW-1:0]        u_waddr, u_raddr;
  logic [MW-1:0]         u_wdata, u_rdata;
  logic                  c_we;
  logic [PW-1:0]         c_waddr, c_raddr;
  logic [COUNT_BITS-1:0] c_wdata, c_rdata;

  rpfa_ram #(.WIDTH(MW), .DEPTH(NW)) u_used_ram (
    .clk_i  (clk_i),
    .we_i   (u_we),
    .waddr_i(u_waddr),
    .wdata_i(u_wdata),
    .raddr_i(u_raddr),
    .rdata_o(u_rdata)
  );

  rpfa_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_PAGES)) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .raddr_i(c_raddr),
    .rdata_o(c_rdata)
  );

  // shared decisions
  logic [PW-1:0]     cm1, h, run_top, lim;
  logic [5:0]        mbo;
  logic [LW-1:0]     fst, lst, pn_ext, n_ext, need, p_bulk;
  logic              pn_bad, one_skip, one_hit, one_last;
  logic [MW_LOG-1:0] one_lo, one_hi, one_j, hb, uw_lo, uw_hi;
  logic [MW-1:0]     one_free, maskr, run_free;
  logic              run_all, run_none, run_fit, bit_free, bit_hit;
  logic [LW-1:0]     lnew;
  logic [5:0]        c_words;
  logic              u_bit;
  logic [COUNT_BITS-1:0] cmax;

  always_comb begin
    cmax   = '1;
    cm1    = PW'(cnt_q - CW'(1));
    h      = (hint_q < cm1) ? hint_q : cm1;
    fst    = class_first(cls_q);
    lst    = class_last(cls_q);
    one_skip = fst > LW'(h);
    pn_ext = LW'(req_q.page_number);
    pn_bad = pn_ext >= LW'(cnt_q);
    n_ext  = LW'(req_q.run_length);
    // run top: min of count-1, hint and the address limit
    mbo    = req_q.max_address_bits - MIN_ADDR_BITS;
    lim    = PW'((LW'(1) << mbo) - LW'(1));
    run_top = (hint_q < cm1) ? hint_q : cm1;
    if (mbo < 6'(PW) && lim < run_top) run_top = lim;
    // upward scan of one word
    one_lo   = (w_q == a_q[PW-1:MW_LOG]) ? a_q[MW_LOG-1:0] : '0;
    one_hi   = (w_q == b_q[PW-1:MW_LOG]) ? b_q[MW_LOG-1:0] : '1;
    one_free = ~u_rdata & range_mask(one_lo, one_hi);
    one_hit  = |one_free;
    one_j    = lowest_set(one_free);
    one_last = w_q == b_q[PW-1:MW_LOG];
    // downward scan of one word
    hb       = (w_q == top_q[PW-1:MW_LOG]) ? top_q[MW_LOG-1:0] : '1;
    maskr    = range_mask('0, hb);
    run_free = ~u_rdata & maskr;
    run_all  = run_free == maskr;
    run_none = run_free == '0;
    c_words  = 6'(hb) + 6'd1;
    need     = n_ext - len_q;
    run_fit  = need <= LW'(c_words);
    p_bulk   = LW'({w_q, hb}) + LW'(1) - need;
    bit_free = fw_q[bit_q];
    lnew     = bit_free ? len_q + LW'(1) : '0;
    bit_hit  = lnew == n_ext;
    // marking a run in the bitmap
    uw_lo    = (w_q == p_q[PW-1:MW_LOG]) ? p_q[MW_LOG-1:0] : '0;
    uw_hi    = (w_q == e_q[PW-1:MW_LOG]) ? e_q[MW_LOG-1:0] : '1;
    u_bit    = u_rdata[req_q.page_number[MW_LOG-1:0]];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:    if (clr_q == WAW'(NW - 1)) state_d = S_IDLE;
      S_IDLE:     if (start) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (req_q.func)
          FN_ALLOC_ONE: state_d = (cnt_q == '0) ? S_IDLE : S_ONE_CLS;
          FN_ALLOC_RUN: begin
            if (n_ext == '0 || cnt_q == '0 || req_q.max_address_bits < MIN_ADDR_BITS)
              state_d = S_IDLE;
            else
              state_d = S_RUN_RD;
          end
          FN_REF, FN_DEREF, FN_QUERY: state_d = pn_bad ? S_IDLE : S_PG_EX;
          default: state_d = S_IDLE;
        endcase
      end
      S_ONE_CLS:  state_d = one_skip ? S_ONE_CLS : S_ONE_RD;
      S_ONE_RD:   state_d = S_ONE_CHK;
      S_ONE_CHK: begin
        if (one_hit) state_d = S_IDLE;
        else if (one_last) state_d = (cls_q == CLS_LOWEST) ? S_IDLE : S_ONE_CLS;
        else state_d = S_ONE_RD;
      end
      S_RUN_RD:   state_d = S_RUN_CHK;
      S_RUN_CHK: begin
        if (run_all && run_fit) state_d = S_RUN_URD;
        else if (!run_all && !run_none) state_d = S_RUN_BIT;
        else state_d = (w_q == '0) ? S_IDLE : S_RUN_RD;
      end
      S_RUN_BIT: begin
        if (bit_hit) state_d = S_RUN_URD;
        else if (bit_q == '0) state_d = (w_q == '0) ? S_IDLE : S_RUN_RD;
      end
      S_RUN_URD:  state_d = S_RUN_UWR;
      S_RUN_UWR:  if (w_q == e_q[PW-1:MW_LOG]) state_d = S_RUN_CNT;
                  else state_d = S_RUN_URD;
      S_RUN_CNT:  if (q_q == e_q) state_d = S_IDLE;
      S_PG_EX:    state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    hint_d = hint_q;   used_d = used_q;  cls_d = cls_q;  w_d = w_q;
    clr_d = clr_q;     a_d = a_q;        b_d = b_q;      top_d = top_q;
    p_d = p_q;         e_d = e_q;        q_d = q_q;      len_d = len_q;
    bit_d = bit_q;     fw_d = fw_q;
    status_d = status_q; rpage_d = rpage_q; rcnt_d = rcnt_q;
    done_d = 1'b0;
    u_we = 1'b0; u_waddr = w_q; u_wdata = '0; u_raddr = w_q;
    c_we = 1'b0; c_waddr = q_q; c_wdata = '0;
    c_raddr = req_q.page_number[PW-1:0];
    case (state_q)
      S_CLEAR: begin
        u_we = 1'b1;
        u_waddr = clr_q;
        clr_d = clr_q + WAW'(1);
      end
      S_DISPATCH: begin
        status_d = ST_OK; rpage_d = '0; rcnt_d = '0;
        u_raddr = req_q.page_number[PW-1:MW_LOG];
        case (req_q.func)
          FN_ALLOC_ONE: begin
            cls_d = CLS_HIGHEST;
            if (cnt_q == '0) begin
              status_d = ST_NOMEM; done_d = 1'b1;
            end
          end
          FN_ALLOC_RUN: begin
            top_d = run_top;
            w_d   = run_top[PW-1:MW_LOG];
            len_d = '0;
            if (n_ext == '0 || cnt_q == '0 || req_q.max_address_bits < MIN_ADDR_BITS) begin
              status_d = ST_NOMEM; done_d = 1'b1;
            end
          end
          FN_REF, FN_DEREF, FN_QUERY: begin
            if (pn_bad) begin
              status_d = ST_RANGE; done_d = 1'b1;
            end
          end
          default: done_d = 1'b1;
        endcase
      end
      S_ONE_CLS: begin
        if (one_skip) begin
          cls_d = cls_q - 3'd1;
        end else begin
          a_d = fst[PW-1:0];
          b_d = (lst < LW'(h)) ? lst[PW-1:0] : h;
          w_d = fst[PW-1:MW_LOG];
        end
      end
      S_ONE_CHK: begin
        if (one_hit) begin
          u_we = 1'b1;
          u_wdata = u_rdata | (MW'(1) << one_j);
          c_we = 1'b1;
          c_waddr = {w_q, one_j};
          c_wdata = COUNT_BITS'(1);
          used_d = used_q + CW'(1);
          rpage_d = {w_q, one_j};
          rcnt_d = COUNT_BITS'(1);
          done_d = 1'b1;
        end else if (one_last) begin
          // class exhausted below the hint
          hint_d = a_q;
          cls_d = cls_q - 3'd1;
          if (cls_q == CLS_LOWEST) begin
            status_d = ST_NOMEM; done_d = 1'b1;
          end
        end else begin
          w_d = w_q + WAW'(1);
        end
      end
      S_RUN_CHK: begin
        if (run_all && run_fit) begin
          p_d = p_bulk[PW-1:0];
          e_d = PW'(p_bulk + n_ext - LW'(1));
          w_d = p_bulk[PW-1:MW_LOG];
        end else if (!run_all && !run_none) begin
          fw_d = run_free;
          bit_d = hb;
        end else begin
          len_d = run_all ? len_q + LW'(c_words) : '0;
          w_d = w_q - WAW'(1);
          if (w_q == '0) begin
            status_d = ST_NOMEM; done_d = 1'b1;
          end
        end
      end
      S_RUN_BIT: begin
        len_d = lnew;
        bit_d = bit_q - MW_LOG'(1);
        if (bit_hit) begin
          p_d = {w_q, bit_q};
          e_d = PW'(LW'({w_q, bit_q}) + n_ext - LW'(1));
          w_d = w_q;
        end else if (bit_q == '0) begin
          w_d = w_q - WAW'(1);
          if (w_q == '0) begin
            status_d = ST_NOMEM; done_d = 1'b1;
          end
        end
      end
      S_RUN_UWR: begin
        u_we = 1'b1;
        u_wdata = u_rdata | range_mask(uw_lo, uw_hi);
        w_d = w_q + WAW'(1);
        q_d = p_q;
      end
      S_RUN_CNT: begin
        c_we = 1'b1;
        c_wdata = COUNT_BITS'(1);
        q_d = q_q + PW'(1);
        if (q_q == e_q) begin
          used_d = used_q + CW'(req_q.run_length);
          rpage_d = p_q;
          rcnt_d = COUNT_BITS'(1);
          done_d = 1'b1;
        end
      end
      S_PG_EX: begin
        done_d = 1'b1;
        u_waddr = req_q.page_number[PW-1:MW_LOG];
        c_waddr = req_q.page_number[PW-1:0];
        case (req_q.func)
          FN_REF: begin
            c_we = 1'b1;
            if (!u_bit) begin
              u_we = 1'b1;
              u_wdata = u_rdata | (MW'(1) << req_q.page_number[MW_LOG-1:0]);
              used_d = used_q + CW'(1);
              c_wdata = COUNT_BITS'(1);
            end else if (c_rdata != cmax) begin
              c_wdata = c_rdata + COUNT_BITS'(1);
            end else begin
              c_wdata = c_rdata;
            end
            rcnt_d = c_wdata;
          end
          FN_DEREF: begin
            if (!u_bit) begin
              status_d = ST_FREE;
            end else begin
              if (hint_q < req_q.page_number[PW-1:0]) hint_d = req_q.page_number[PW-1:0];
              c_we = 1'b1;
              if (c_rdata <= COUNT_BITS'(1)) begin
                u_we = 1'b1;
                u_wdata = u_rdata & ~(MW'(1) << req_q.page_number[MW_LOG-1:0]);
                used_d = used_q - CW'(1);
                c_wdata = '0;
              end else begin
                c_wdata = c_rdata - COUNT_BITS'(1);
              end
              rcnt_d = c_wdata;
            end
          end
          default: rcnt_d = u_bit ? c_rdata : '0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= CW'(NUM_PAGES);
      hint_q  <= PW'(NUM_PAGES - 1);
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hint_q  <= hint_d;
      used_q  <= used_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cnt_q <= (LW'(cfg_wdata_i) >= LW'(NUM_PAGES)) ? CW'(NUM_PAGES) : CW'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) req_q <= req_i;
    cls_q <= cls_d;   w_q <= w_d;     a_q <= a_d;     b_q <= b_d;
    top_q <= top_d;   p_q <= p_d;     e_q <= e_d;     q_q <= q_d;
    len_q <= len_d;   bit_q <= bit_d; fw_q <= fw_d;
    status_q <= status_d;
    rpage_q  <= rpage_d;
    rcnt_q   <= rcnt_d;
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = '{status:      status_q,
                    result_page: 16'(rpage_q),
                    ref_count:   16'(rcnt_q),
                    used_pages:  17'(used_q)};

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reference-counted page frame allocator. A
// directed table covers the corner cases. Random items then run under several
// page counts. Results are checked against the table's expected values or an
// in-bench model of the bitmaps, counts and free hint.
// ----------------------------------------------------------------------------
module tb_top;
  import rpfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGES     = 65536;
  localparam int unsigned GRP       = 32;
  localparam logic [15:0] CNT_SAT   = 16'hFFFF;
  localparam logic [2:0]  FN_UNDEF  = 3'd7;
  localparam longint      LIMIT     = 64'd40_000_000;
  localparam int          N_RANDOM  = 200;
  localparam int          N_DIR     = 25;

  typedef struct {
    rpfa_req_t req;
    bit        typed;
    rpfa_rsp_t rsp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  rpfa_req_t req_i = '0;
  logic done_o;
  rpfa_rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  refcounted_page_frame_allocator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator model state
  bit          pg_used [PAGES];
  bit          grp_full[PAGES/GRP];
  logic [15:0] pg_refs [PAGES];
  int unsigned used_cnt = 0;
  int unsigned hint_pg  = PAGES - 1;
  int unsigned npages   = PAGES;

  rpfa_rsp_t   rsp_exp_q[$];
  int unsigned taken_q[$];
  int          n_err = 0;
  int          idle_pct = 10;
  longint      cyc = 0;

  function automatic int unsigned eff_pages();
    return (npages < PAGES) ? npages : PAGES;
  endfunction

  function automatic void regroup(int unsigned p);
    int unsigned base;
    bit full;
    base = (p / GRP) * GRP;
    full = 1'b1;
    for (int k = 0; k < GRP; k++) if (!pg_used[base + k]) full = 1'b0;
    grp_full[p / GRP] = full;
  endfunction

  function automatic void take_page(int unsigned p);
    if (!pg_used[p]) begin
      pg_used[p] = 1'b1;
      used_cnt++;
    end
    pg_refs[p] = 16'd1;
    regroup(p);
  endfunction

  function automatic bit lowest_free(longint a, longint b, output int unsigned pg);
    longint p;
    p = a;
    while (p <= b) begin
      if (grp_full[p / GRP]) begin
        p = (p / GRP + 1) * GRP;
        continue;
      end
      if (!pg_used[p]) begin
        pg = p;
        return 1'b1;
      end
      p++;
    end
    return 1'b0;
  endfunction

  function automatic bit grab_one(output int unsigned pg);
    int unsigned cls_bits[6];
    int unsigned cnt;
    longint first, last, lim;
    cls_bits = '{0, 16, 20, 24, 32, 64};
    cnt = eff_pages();
    if (cnt == 0) return 1'b0;
    // highest address class first
    for (int i = 5; i >= 1; i--) begin
      first = (i == 1) ? 0 : (64'sd1 <<< (cls_bits[i-1] - 12));
      last  = (64'sd1 <<< (cls_bits[i] - 12)) - 1;
      lim   = (hint_pg > cnt - 1) ? cnt - 1 : hint_pg;
      if (first > lim) continue;
      if (last > lim) last = lim;
      if (lowest_free(first, last, pg)) begin
        take_page(pg);
        return 1'b1;
      end
      hint_pg = first;
    end
    return 1'b0;
  endfunction

  function automatic bit grab_run(int unsigned n, int unsigned mb, output int unsigned pg);
    int unsigned cnt, len;
    longint top, p, g, lim;
    cnt = eff_pages();
    len = 0;
    if (n == 0 || cnt == 0 || mb < 12) return 1'b0;
    top = cnt - 1;
    if (hint_pg < top) top = hint_pg;
    if (mb - 12 < 40) begin
      lim = (64'sd1 <<< (mb - 12)) - 1;
      if (lim < top) top = lim;
    end
    // walk down, lowest page of the highest free run wins
    p = top;
    while (p >= 0) begin
      g = p / GRP;
      if (grp_full[g]) begin
        len = 0;
        p = g * GRP - 1;
        continue;
      end
      if (pg_used[p]) len = 0;
      else len++;
      if (len == n) begin
        for (int unsigned k = 0; k < n; k++) take_page(p + k);
        pg = p;
        return 1'b1;
      end
      p--;
    end
    return 1'b0;
  endfunction

  function automatic rpfa_rsp_t apply_item(rpfa_req_t r);
    rpfa_rsp_t o;
    int unsigned pg, pn, cnt;
    o = '0;
    pn = r.page_number;
    cnt = eff_pages();
    pg = 0;
    case (r.func)
      FN_ALLOC_ONE: begin
        if (grab_one(pg)) begin
          o.result_page = pg[15:0];
          o.ref_count = 16'd1;
          taken_q.push_back(pg);
        end else o.status = ST_NOMEM;
      end
      FN_ALLOC_RUN: begin
        if (grab_run(r.run_length, r.max_address_bits, pg)) begin
          o.result_page = pg[15:0];
          o.ref_count = 16'd1;
          taken_q.push_back(pg);
        end else o.status = ST_NOMEM;
      end
      FN_REF: begin
        if (pn >= cnt) o.status = ST_RANGE;
        else begin
          if (!pg_used[pn]) begin
            pg_used[pn] = 1'b1;
            used_cnt++;
            pg_refs[pn] = 16'd1;
            regroup(pn);
          end else if (pg_refs[pn] != CNT_SAT) begin
            pg_refs[pn]++;
          end
          o.ref_count = pg_refs[pn];
        end
      end
      FN_DEREF: begin
        if (pn >= cnt) o.status = ST_RANGE;
        else if (!pg_used[pn]) o.status = ST_FREE;
        else begin
          if (hint_pg < pn) hint_pg = pn;
          if (pg_refs[pn] <= 1) begin
            pg_refs[pn] = '0;
            pg_used[pn] = 1'b0;
            used_cnt--;
            grp_full[pn / GRP] = 1'b0;
          end else pg_refs[pn]--;
          o.ref_count = pg_refs[pn];
        end
      end
      FN_QUERY: begin
        if (pn >= cnt) o.status = ST_RANGE;
        else o.ref_count = pg_used[pn] ? pg_refs[pn] : '0;
      end
      default: ;
    endcase
    if (taken_q.size() > 64) void'(taken_q.pop_front());
    o.used_pages = used_cnt[16:0];
    return o;
  endfunction

  // hands one item over and records what it should produce
  task automatic issue(rpfa_req_t r, bit typed, rpfa_rsp_t t);
    rpfa_rsp_t p;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    p = apply_item(r);
    rsp_exp_q.push_back(typed ? t : p);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (rsp_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_page_count(int unsigned v);
    drain();
    while (busy) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[16:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    npages = v & 32'h1FFFF;
  endtask

  function automatic int unsigned pick_page();
    int unsigned sel, span;
    sel = $urandom_range(0, 99);
    span = eff_pages() + 2;
    if (sel < 50 && taken_q.size() != 0) return taken_q[$urandom_range(0, taken_q.size() - 1)];
    if (sel < 85) return $urandom_range(0, span);
    if (sel < 95) return $urandom_range(0, 20'hFFFFF);
    return (sel & 1) ? 20'hFFFFF : 0;
  endfunction

  function automatic rpfa_req_t rand_item();
    rpfa_req_t r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    r.page_number = pick_page();
    r.run_length = $urandom_range(1, 8);
    r.max_address_bits = $urandom_range(12, 32);
    if (sel < 30) r.func = FN_ALLOC_ONE;
    else if (sel < 45) r.func = FN_ALLOC_RUN;
    else if (sel < 65) r.func = FN_REF;
    else if (sel < 90) r.func = FN_DEREF;
    else if (sel < 98) r.func = FN_QUERY;
    else r.func = 3'($urandom_range(5, 7));
    // rare wild run fields so every bit moves; a long length costs a full scan
    if ($urandom_range(0, 99) == 0) r.run_length = $urandom_range(0, 17'h1FFFF);
    if ($urandom_range(0, 19) == 0) r.max_address_bits = $urandom_range(0, 63);
    return r;
  endfunction

  // result checking, no back pressure
  always @(posedge clk_i) begin
    rpfa_rsp_t e;
    if (rst_ni && done_o) begin
      if (rsp_exp_q.size() == 0) begin
        $error("unexpected item status %0d page %0d", rsp_o.status, rsp_o.result_page);
        n_err++;
      end else begin
        e = rsp_exp_q.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp_o.status);
          n_err++;
        end
        if (rsp_o.result_page !== e.result_page) begin
          $error("result_page exp %0d got %0d", e.result_page, rsp_o.result_page);
          n_err++;
        end
        if (rsp_o.ref_count !== e.ref_count) begin
          $error("ref_count exp %0d got %0d", e.ref_count, rsp_o.ref_count);
          n_err++;
        end
        if (rsp_o.used_pages !== e.used_pages) begin
          $error("used_pages exp %0d got %0d", e.used_pages, rsp_o.used_pages);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("[refcounted_page_frame_allocator_top] ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab[N_DIR];
    int unsigned phase_pc[7];
    rpfa_req_t r;
    dir_tab = '{
      '{'{FN_QUERY, 20'd0, 17'd0, 6'd0}, 1'b1, '{ST_OK, 16'd0, 16'd0, 17'd0}},
      '{'{FN_QUERY, 20'hFFFFF, 17'd0, 6'd0}, 1'b1, '{ST_RANGE, 16'd0, 16'd0, 17'd0}},
      '{'{FN_DEREF, 20'd5, 17'd0, 6'd0}, 1'b1, '{ST_FREE, 16'd0, 16'd0, 17'd0}},
      '{'{FN_ALLOC_ONE, 20'd0, 17'd0, 6'd0}, 1'b1, '{ST_OK, 16'd4096, 16'd1, 17'd1}},
      '{'{FN_REF, 20'd4096, 17'd0, 6'd0}, 1'b1, '{ST_OK, 16'd0, 16'd2, 17'd1}},
      '{'{FN_UNDEF, 20'd7, 17'd3, 6'd20}, 1'b1, '{ST_OK, 16'd0, 16'd0, 17'd1}},
      '{'{FN_ALLOC_RUN, 20'd0, 17'd0, 6'd32}, 1'b1, '{ST_NOMEM, 16'd0, 16'd0, 17'd1}},
      '{'{FN_ALLOC_RUN, 20'd0, 17'd1, 6'd11}, 1'b1, '{ST_NOMEM, 16'd0, 16'd0, 17'd1}},
      '{'{FN_ALLOC_RUN, 20'd0, 17'd1, 6'd12}, 1'b1, '{ST_OK, 16'd0, 16'd1, 17'd2}},
      '{'{FN_ALLOC_RUN, 20'd0, 17'd2, 6'd12}, 1'b1, '{ST_NOMEM, 16'd0, 16'd0, 17'd2}},
      '{'{FN_DEREF, 20'd4096, 17'd0, 6'd0}, 1'b1, '{ST_OK, 16'd0, 16'd1, 17'd2}},
      '{'{FN_DEREF, 20'd4096, 17'd0, 6'd0}, 1'b1, '{ST_OK, 16'd0, 16'd0, 17'd1}},
      '{'{FN_REF, 20'd65535, 17'd0, 6'd0}, 1'b1, '{ST_OK, 16'd0, 16'd1, 17'd2}},
      '{'{FN_QUERY, 20'd65536, 17'd0, 6'd0}, 1'b1, '{ST_RANGE, 16'd0, 16'd0, 17'd2}},
      '{'{FN_ALLOC_RUN, 20'd0, 17'h1FFFF, 6'h3F}, 1'b1, '{ST_NOMEM, 16'd0, 16'd0, 17'd2}},
      '{'{FN_ALLOC_RUN, 20'd0, 17'd65536, 6'h3F}, 1'b1, '{ST_NOMEM, 16'd0, 16'd0, 17'd2}},
      '{'{FN_ALLOC_RUN, 20'd0, 17'd16, 6'd16}, 1'b1, '{ST_NOMEM, 16'd0, 16'd0, 17'd2}},
      '{'{FN_ALLOC_RUN, 20'd0, 17'd15, 6'd16}, 1'b1, '{ST_OK, 16'd1, 16'd1, 17'd17}},
      '{'{FN_ALLOC_ONE, 20'd0, 17'd0, 6'd0}, 1'b1, '{ST_OK, 16'd4096, 16'd1, 17'd18}},
      '{'{FN_DEREF, 20'd0, 17'd0, 6'd0}, 1'b1, '{ST_OK, 16'd0, 16'd0, 17'd17}},
      '{'{FN_ALLOC_RUN, 20'd0, 17'd4, 6'd20}, 1'b0, '0},
      '{'{FN_ALLOC_ONE, 20'd0, 17'd0, 6'd0}, 1'b0, '0},
      '{'{FN_QUERY, 20'd1, 17'd0, 6'd0}, 1'b0, '0},
      '{'{FN_REF, 20'hFFFFF, 17'd0, 6'd0}, 1'b1, '{ST_RANGE, 16'd0, 16'd0, 17'd22}},
      '{'{FN_DEREF, 20'd65535, 17'd0, 6'd0}, 1'b1, '{ST_OK, 16'd0, 16'd0, 17'd21}}
    };
    phase_pc = '{40, 1024, 1, 0, 17'h1FFFF, 300, 65536};
    for (int i = 0; i < PAGES; i++) begin
      pg_used[i] = 1'b0;
      pg_refs[i] = '0;
    end
    for (int i = 0; i < PAGES / GRP; i++) grp_full[i] = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 10;
    for (int i = 0; i < N_DIR; i++) issue(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);

    for (int ph = 0; ph < 7; ph++) begin
      write_page_count(phase_pc[ph]);
      idle_pct = (ph < 3) ? 10 : (ph < 5) ? 76 : 0;
      for (int i = 0; i < N_RANDOM; i++) begin
        r = rand_item();
        issue(r, 1'b0, '0);
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (n_err == 0) begin
      $display("[refcounted_page_frame_allocator_top] OK");
    end else begin
      $display("[refcounted_page_frame_allocator_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rpfa_pkg.sv
design/rpfa_ram.sv
design/refcounted_page_frame_allocator_top.sv
test/tb_top.sv
